// ===== design/distance_pid_with_drift_trim_macros.svh =====
// Assertion macros for the distance PID block.
// Used by the controller and datapath modules; no other dependencies.
`ifndef DISTANCE_PID_WITH_DRIFT_TRIM_MACROS_SVH
`define DISTANCE_PID_WITH_DRIFT_TRIM_MACROS_SVH
`ifndef SYNTHESIS
`define DPT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define DPT_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DPT_ASSERT(label, clk, rst, prop)
`define DPT_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== design/dpt_pkg.sv =====
// Shared types and constants for the distance PID with drift trim.
// No dependencies.
package dpt_pkg;
   localparam int POSITION_BITS_DEF = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_ABORT = 2'd2;
   localparam logic [2:0] CSR_TARGET = 3'd0;
   localparam logic [2:0] CSR_WINDOW = 3'd1;
   localparam logic [2:0] CSR_ILIMIT = 3'd2;
   localparam logic [2:0] CSR_KP = 3'd3;
   localparam logic [2:0] CSR_KI = 3'd4;
   localparam logic [2:0] CSR_KD = 3'd5;
   localparam logic [2:0] CSR_DRIFT = 3'd6;
   localparam logic [2:0] CSR_TLIMIT = 3'd7;

   // datapath steps sequenced by the controller
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_ERROR = 3'd1,   // error, integral, derivative, drift
      OP_PTERM = 3'd2,
      OP_ITERM = 3'd3,
      OP_DTERM = 3'd4,
      OP_SCALE = 3'd5,   // saturate power, update scales
      OP_RIGHT = 3'd6,
      OP_LEFT  = 3'd7
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       start;      // latch baselines, clear state
      logic       sample;     // evaluate time limit and capture inputs
   } cmd_type;

   typedef struct packed {
      logic       timeout;    // elapsed >= limit
      logic       done_band;  // |error| < 5
   } stat_type;
endpackage

// ===== design/dpt_datapath.sv =====
// Arithmetic for the distance PID: error, integral, shared multiplier, scales.
// Depends on dpt_pkg and the macros header.
`include "distance_pid_with_drift_trim_macros.svh"
module dpt_datapath #(
   parameter int POSITION_BITS = dpt_pkg::POSITION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dpt_pkg::cmd_type            cmd_in,
   output dpt_pkg::stat_type           stat_out,
   input  logic signed [23:0]          position,
   input  logic signed [23:0]          rotation_cdeg,
   input  logic        [15:0]          elapsed_ms,
   input  logic signed [23:0]          target_counts,
   input  logic        [15:0]          integral_window,
   input  logic        [23:0]          integral_limit,
   input  logic        [23:0]          kp_gain,
   input  logic        [23:0]          ki_gain,
   input  logic        [23:0]          kd_gain,
   input  logic        [15:0]          drift_gain,
   input  logic        [15:0]          time_limit_ms,
   output logic signed [15:0]          right_drive,
   output logic signed [15:0]          left_drive
);
   logic signed [23:0] base_pos_ff, base_pos_in, base_rot_ff, base_rot_in;
   logic signed [24:0] prev_err_ff, prev_err_in, err_ff, err_in;
   logic signed [25:0] integ_ff, integ_in, deriv_ff, deriv_in;
   logic signed [19:0] rscale_ff, rscale_in, lscale_ff, lscale_in;
   logic signed [24:0] drift_ff, drift_in;
   logic signed [51:0] acc_ff, acc_in;
   logic signed [24:0] pos_ff, pos_in, rot_ff, rot_in;
   logic               time_ff, time_in;
   logic signed [15:0] rdrv_ff, rdrv_in, ldrv_ff, ldrv_in;

   logic signed [POSITION_BITS-1:0] trav_w;
   logic signed [25:0]  err_raw, ilim, isum;
   logic signed [24:0]  err_sat, aerr;
   logic signed [26:0]  mul_a;
   logic signed [24:0]  mul_b;
   logic signed [51:0]  prod;
   logic signed [51:0]  pwr_sat;
   logic signed [24:0]  adrift;
   logic signed [41:0]  sc_raw;
   logic signed [19:0]  sc_sat;
   logic signed [51:0]  drv_raw;
   logic signed [27:0]  drv_sh;
   logic signed [15:0]  drv_sat;

   localparam logic signed [51:0] PWR_MAX = 52'sd6553600;

   always_comb begin
      trav_w = POSITION_BITS'(pos_ff) - POSITION_BITS'(base_pos_ff);
      err_raw = 26'(target_counts) - 26'(trav_w);
      if (err_raw > 26'sd16777215) err_sat = 25'sd16777215;
      else if (err_raw < -26'sd16777216) err_sat = -25'sd16777216;
      else err_sat = err_raw[24:0];
      aerr = err_sat[24] ? -err_sat : err_sat; // -2^24 wraps; handled below
      ilim = 26'(integral_limit);
      if ((err_sat != -25'sd16777216) && ({1'b0, aerr} < 26'(integral_window)))
         isum = integ_ff + 26'(err_sat);
      else
         isum = '0;
      if (isum > ilim) isum = ilim;
      else if (isum < -ilim) isum = -ilim;
   end

   // shared multiplier, one product per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd_in.op)
         dpt_pkg::OP_PTERM: begin mul_a = 27'(err_ff); mul_b = {1'b0, kp_gain}; end
         dpt_pkg::OP_ITERM: begin mul_a = 27'(integ_ff); mul_b = {1'b0, ki_gain}; end
         dpt_pkg::OP_DTERM: begin mul_a = 27'(deriv_ff); mul_b = {1'b0, kd_gain}; end
         dpt_pkg::OP_SCALE: begin
            mul_a = 27'(adrift);
            mul_b = {9'd0, drift_gain};
         end
         // power is already saturated to +-100 percent, so its low bits carry it
         dpt_pkg::OP_RIGHT: begin mul_a = acc_ff[26:0]; mul_b = 25'(rscale_ff); end
         dpt_pkg::OP_LEFT: begin mul_a = acc_ff[26:0]; mul_b = 25'(lscale_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod = 52'(mul_a) * 52'(mul_b);
   end

   always_comb begin
      adrift = drift_ff[24] ? -drift_ff : drift_ff;
      sc_raw = 42'sd65536 - 42'(prod);
      if (sc_raw > 42'sd524287) sc_sat = 20'sd524287;
      else if (sc_raw < -42'sd524288) sc_sat = -20'sd524288;
      else sc_sat = sc_raw[19:0];
      if (acc_ff > PWR_MAX) pwr_sat = PWR_MAX;
      else if (acc_ff < -PWR_MAX) pwr_sat = -PWR_MAX;
      else pwr_sat = acc_ff;
      drv_raw = prod + 52'sd8388608;
      drv_sh = drv_raw[51:24];
      if (drv_sh > 28'sd25600) drv_sat = 16'sd25600;
      else if (drv_sh < -28'sd25600) drv_sat = -16'sd25600;
      else drv_sat = drv_sh[15:0];
   end

   always_comb begin
      base_pos_in = base_pos_ff; base_rot_in = base_rot_ff;
      prev_err_in = prev_err_ff; err_in = err_ff; integ_in = integ_ff;
      deriv_in = deriv_ff; rscale_in = rscale_ff; lscale_in = lscale_ff;
      drift_in = drift_ff; acc_in = acc_ff; pos_in = pos_ff; rot_in = rot_ff;
      time_in = time_ff; rdrv_in = rdrv_ff; ldrv_in = ldrv_ff;
      if (cmd_in.start) begin
         base_pos_in = position; base_rot_in = rotation_cdeg;
         prev_err_in = '0; integ_in = '0;
         rscale_in = 20'sd65536; lscale_in = 20'sd65536;
      end
      if (cmd_in.sample) begin
         pos_in = 25'(position); rot_in = 25'(rotation_cdeg);
         time_in = elapsed_ms >= time_limit_ms;
         rdrv_in = '0; ldrv_in = '0;
      end
      case (cmd_in.op)
         dpt_pkg::OP_ERROR: begin
            err_in = err_sat;
            integ_in = isum;
            deriv_in = 26'(err_sat) - 26'(prev_err_ff);
            prev_err_in = err_sat;
            drift_in = rot_ff - 25'(base_rot_ff);
         end
         dpt_pkg::OP_PTERM: acc_in = prod;
         dpt_pkg::OP_ITERM: acc_in = acc_ff + prod;
         dpt_pkg::OP_DTERM: acc_in = acc_ff + prod;
         dpt_pkg::OP_SCALE: begin
            acc_in = (err_ff > -25'sd5 && err_ff < 25'sd5) ? '0 : pwr_sat;
            if (err_ff > 0 && drift_ff < 0) rscale_in = sc_sat;
            if (err_ff > 0 && drift_ff > 0) lscale_in = sc_sat;
         end
         dpt_pkg::OP_RIGHT: rdrv_in = drv_sat;
         dpt_pkg::OP_LEFT: ldrv_in = drv_sat;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_pos_ff <= '0; base_rot_ff <= '0; prev_err_ff <= '0; integ_ff <= '0;
         rscale_ff <= 20'sd65536; lscale_ff <= 20'sd65536;
         rdrv_ff <= '0; ldrv_ff <= '0;
      end else begin
         base_pos_ff <= base_pos_in; base_rot_ff <= base_rot_in;
         prev_err_ff <= prev_err_in; integ_ff <= integ_in;
         rscale_ff <= rscale_in; lscale_ff <= lscale_in;
         rdrv_ff <= rdrv_in; ldrv_ff <= ldrv_in;
      end
      err_ff <= err_in; deriv_ff <= deriv_in; drift_ff <= drift_in; acc_ff <= acc_in;
      pos_ff <= pos_in; rot_ff <= rot_in; time_ff <= time_in;
   end

   assign stat_out.timeout = time_ff;
   assign stat_out.done_band = err_ff > -25'sd5 && err_ff < 25'sd5;
   assign right_drive = rdrv_ff;
   assign left_drive = ldrv_ff;

   `DPT_ASSERT(a_integ_clamped, clock, reset,
      (integ_ff <= $signed({2'b00, integral_limit})) || $past(cmd_in.op != dpt_pkg::OP_ERROR))
   `DPT_ASSERT(a_drive_range, clock, reset,
      (rdrv_ff <= 16'sd25600) && (rdrv_ff >= -16'sd25600))
   `DPT_ASSERT(a_start_scale, clock, reset,
      cmd_in.start |=> (rscale_ff == 20'sd65536) && (lscale_ff == 20'sd65536))
endmodule

// ===== design/dpt_control.sv =====
// Controller for the distance PID: handshakes, move status, step sequencing.
// Depends on dpt_pkg and the macros header.
`include "distance_pid_with_drift_trim_macros.svh"
module dpt_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_finished,
   output logic              rsp_timed_out,
   output logic              clear_drive,
   output dpt_pkg::cmd_type  cmd_out,
   input  dpt_pkg::stat_type stat_in
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_ERR, S_P, S_I, S_D, S_SCALE, S_RIGHT, S_LEFT, S_OUT
   } state_type;

   state_type state_ff;
   logic      over_ff, bytime_ff, fin_ff, to_ff, zero_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_finished = fin_ff;
   assign rsp_timed_out = to_ff;
   assign clear_drive = zero_ff;

   always_comb begin
      cmd_out = '{op: dpt_pkg::OP_NONE, start: 1'b0, sample: 1'b0};
      if (state_ff == S_IDLE && req_valid) begin
         cmd_out.start = req_cmd == dpt_pkg::CMD_START;
         cmd_out.sample = 1'b1;
      end
      case (state_ff)
         S_ERR: cmd_out.op = dpt_pkg::OP_ERROR;
         S_P: cmd_out.op = dpt_pkg::OP_PTERM;
         S_I: cmd_out.op = dpt_pkg::OP_ITERM;
         S_D: cmd_out.op = dpt_pkg::OP_DTERM;
         S_SCALE: cmd_out.op = dpt_pkg::OP_SCALE;
         S_RIGHT: cmd_out.op = dpt_pkg::OP_RIGHT;
         S_LEFT: cmd_out.op = dpt_pkg::OP_LEFT;
         default: cmd_out.op = dpt_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; over_ff <= 1'b1; bytime_ff <= 1'b0;
         fin_ff <= 1'b0; to_ff <= 1'b0; zero_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               zero_ff <= 1'b1;
               if (req_cmd == dpt_pkg::CMD_START) begin
                  over_ff <= 1'b0; bytime_ff <= 1'b0;
                  fin_ff <= 1'b0; to_ff <= 1'b0; state_ff <= S_OUT;
               end else if (req_cmd == dpt_pkg::CMD_SAMPLE && !over_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  if (req_cmd == dpt_pkg::CMD_ABORT && !over_ff) begin
                     over_ff <= 1'b1; bytime_ff <= 1'b0;
                     fin_ff <= 1'b1; to_ff <= 1'b0;
                  end else begin
                     fin_ff <= over_ff; to_ff <= over_ff && bytime_ff;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_CHECK: if (stat_in.timeout) begin
               over_ff <= 1'b1; bytime_ff <= 1'b1;
               fin_ff <= 1'b1; to_ff <= 1'b1; state_ff <= S_OUT;
            end else state_ff <= S_ERR;
            S_ERR: state_ff <= S_P;
            S_P: begin
               if (stat_in.done_band) begin over_ff <= 1'b1; bytime_ff <= 1'b0; end
               state_ff <= S_I;
            end
            S_I: state_ff <= S_D;
            S_D: state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_RIGHT;
            S_RIGHT: state_ff <= S_LEFT;
            S_LEFT: begin
               fin_ff <= over_ff; to_ff <= 1'b0; zero_ff <= 1'b0;
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `DPT_ASSERT(a_one_phase, clock, reset, !(req_ready && rsp_valid))
   `DPT_ASSERT(a_timeout_fin, clock, reset, rsp_valid && rsp_timed_out |-> rsp_finished)
   `DPT_ASSERT(a_out_holds, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_finished))
endmodule

// ===== design/distance_pid_with_drift_trim.sv =====
// Straight-drive distance PID with gyro drift trim, top level.
// Requests enter on req_* (cmd, position, rotation_cdeg, elapsed_ms); one
// response leaves on rsp_* per request. Registers are written on csr_*
// (csr_index 0..7 in the order target, window, limit, kp, ki, kd, drift,
// time limit); the user must write them only while no request is in flight.
// The block does not enforce it. A start, an abort or an ignored request
// answers the cycle after acceptance, a sample past the time limit after
// the check state; a control sample answers after the check, error, P, I,
// D, scale, right and left states, one step per cycle through the shared
// multiplier (three gain products, one drift product and two side-drive
// products). The next request is taken the cycle after the response is taken.
// A stalled response holds in its register until rsp_ready.
// Synchronous reset restores register defaults, marks the move over and
// sets both side scales to one.
// Depends on dpt_pkg, dpt_control and dpt_datapath.
module distance_pid_with_drift_trim #(
   parameter int POSITION_BITS = dpt_pkg::POSITION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [23:0] req_position,
   input  logic signed [23:0] req_rotation_cdeg,
   input  logic [15:0]        req_elapsed_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_right_drive,
   output logic signed [15:0] rsp_left_drive,
   output logic               rsp_finished,
   output logic               rsp_timed_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [dpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [23:0]        csr_data
);
   logic signed [23:0] target_ff;
   logic [15:0] window_ff, drift_ff, tlim_ff;
   logic [23:0] ilim_ff, kp_ff, ki_ff, kd_ff;
   dpt_pkg::cmd_type  cmd;
   dpt_pkg::stat_type stat;
   logic clear_drive;
   logic signed [15:0] rdrv, ldrv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0; window_ff <= 16'd1080; ilim_ff <= 24'd50000;
         kp_ff <= 24'd32768; ki_ff <= 24'd66; kd_ff <= 24'd720896;
         drift_ff <= 16'd66; tlim_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            dpt_pkg::CSR_TARGET: target_ff <= csr_data;
            dpt_pkg::CSR_WINDOW: window_ff <= csr_data[15:0];
            dpt_pkg::CSR_ILIMIT: ilim_ff <= csr_data;
            dpt_pkg::CSR_KP: kp_ff <= csr_data;
            dpt_pkg::CSR_KI: ki_ff <= csr_data;
            dpt_pkg::CSR_KD: kd_ff <= csr_data;
            dpt_pkg::CSR_DRIFT: drift_ff <= csr_data[15:0];
            dpt_pkg::CSR_TLIMIT: tlim_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   dpt_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .rsp_valid, .rsp_ready,
      .rsp_finished, .rsp_timed_out, .clear_drive, .cmd_out(cmd), .stat_in(stat)
   );

   dpt_datapath #(.POSITION_BITS(POSITION_BITS)) u_dp (
      .clock, .reset, .cmd_in(cmd), .stat_out(stat),
      .position(req_position), .rotation_cdeg(req_rotation_cdeg),
      .elapsed_ms(req_elapsed_ms), .target_counts(target_ff),
      .integral_window(window_ff), .integral_limit(ilim_ff), .kp_gain(kp_ff),
      .ki_gain(ki_ff), .kd_gain(kd_ff), .drift_gain(drift_ff),
      .time_limit_ms(tlim_ff), .right_drive(rdrv), .left_drive(ldrv)
   );

   assign rsp_right_drive = clear_drive ? '0 : rdrv;
   assign rsp_left_drive = clear_drive ? '0 : ldrv;
endmodule
